/* hdl/occ_bayes_pkg.sv */
// ----------------------------------------------------------------------------
// occ_bayes_pkg
// Shared types and constants of the occupancy cell update pipeline.
// ----------------------------------------------------------------------------
package occ_bayes_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RatioW = 16;
  localparam int unsigned IdxW   = 3;

  // register indexes on the configuration channel
  localparam logic [IdxW-1:0] REG_P_OCC_GIVEN_OCC = 3'd0;
  localparam logic [IdxW-1:0] REG_P_OCC_TO_FREE   = 3'd1;
  localparam logic [IdxW-1:0] REG_P_FREE_TO_FREE  = 3'd2;
  localparam logic [IdxW-1:0] REG_P_FREE_TO_OCC   = 3'd3;
  localparam logic [IdxW-1:0] REG_UNKNOWN_RATIO   = 3'd4;
  localparam logic [IdxW-1:0] REG_CODE_OCCUPIED   = 3'd5;
  localparam logic [IdxW-1:0] REG_CODE_FREE       = 3'd6;
  localparam logic [IdxW-1:0] REG_CODE_UNKNOWN    = 3'd7;

  localparam logic [ByteW-1:0] BYTE_MAX  = 8'd255;
  localparam logic [ByteW-1:0] POST_MIN  = 8'd1;
  localparam logic [ByteW-1:0] POST_MAX  = 8'd254;
  // 0.5 * 255 * 256, offset of the unknown relaxation numerator
  localparam int unsigned      HALF_OFS  = 32640;
  localparam int unsigned      RATIO_ONE = 256;

  typedef struct packed {
    logic [ByteW-1:0] occ;
    logic [ByteW-1:0] free;
    logic [ByteW-1:0] unk;
  } codes_t;

  typedef enum logic [1:0] {
    KIND_BAYES   = 2'd0,
    KIND_UNKNOWN = 2'd1,
    KIND_OTHER   = 2'd2
  } kind_e;

endpackage

/* hdl/occ_bayes_cfg.sv */
// ----------------------------------------------------------------------------
// occ_bayes_cfg
// Configuration register file: probabilities, relaxation ratio and codes.
// ----------------------------------------------------------------------------
module occ_bayes_cfg import occ_bayes_pkg::*; #(
  parameter int unsigned PROB_FRAC_BITS = 16,
  parameter int unsigned CfgW           = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IdxW-1:0]          cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic [PROB_FRAC_BITS:0]  p_occ_given_occ_o,
  output logic [PROB_FRAC_BITS:0]  p_occ_to_free_o,
  output logic [PROB_FRAC_BITS:0]  p_free_to_free_o,
  output logic [PROB_FRAC_BITS:0]  p_free_to_occ_o,
  output logic [RatioW-1:0]        unknown_ratio_o,
  output codes_t                   codes_o
);

  localparam int unsigned PW = PROB_FRAC_BITS + 1;
  // reset probabilities are given in Q0.16 and rescaled to the fraction width
  localparam logic [PW-1:0] RstPoo = PW'((64'd62259 << PROB_FRAC_BITS) >> 16);
  localparam logic [PW-1:0] RstPof = PW'((64'd3277  << PROB_FRAC_BITS) >> 16);
  localparam logic [PW-1:0] RstPff = PW'((64'd39322 << PROB_FRAC_BITS) >> 16);
  localparam logic [PW-1:0] RstPfo = PW'((64'd26214 << PROB_FRAC_BITS) >> 16);

  logic [PW-1:0]     poo_q, pof_q, pff_q, pfo_q;
  logic [RatioW-1:0] ratio_q;
  codes_t            codes_q;
  logic              wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poo_q        <= RstPoo;
      pof_q        <= RstPof;
      pff_q        <= RstPff;
      pfo_q        <= RstPfo;
      ratio_q      <= RatioW'(2560);
      codes_q.occ  <= 8'd255;
      codes_q.free <= 8'd0;
      codes_q.unk  <= 8'd128;
    end else if (wr) begin
      unique case (cfg_index_i)
        REG_P_OCC_GIVEN_OCC: poo_q        <= PW'(cfg_data_i);
        REG_P_OCC_TO_FREE:   pof_q        <= PW'(cfg_data_i);
        REG_P_FREE_TO_FREE:  pff_q        <= PW'(cfg_data_i);
        REG_P_FREE_TO_OCC:   pfo_q        <= PW'(cfg_data_i);
        REG_UNKNOWN_RATIO:   ratio_q      <= cfg_data_i[RatioW-1:0];
        REG_CODE_OCCUPIED:   codes_q.occ  <= cfg_data_i[ByteW-1:0];
        REG_CODE_FREE:       codes_q.free <= cfg_data_i[ByteW-1:0];
        REG_CODE_UNKNOWN:    codes_q.unk  <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign p_occ_given_occ_o = poo_q;
  assign p_occ_to_free_o   = pof_q;
  assign p_free_to_free_o  = pff_q;
  assign p_free_to_occ_o   = pfo_q;
  assign unknown_ratio_o   = ratio_q;
  assign codes_o           = codes_q;

endmodule

/* hdl/occ_bayes_front.sv */
// ----------------------------------------------------------------------------
// occ_bayes_front
// Two pipeline stages: code decode and products, then dividend and divisor.
// ----------------------------------------------------------------------------
module occ_bayes_front import occ_bayes_pkg::*; #(
  parameter int unsigned PROB_FRAC_BITS = 16,
  parameter int unsigned DW             = 25,
  parameter int unsigned NW             = 33
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ByteW-1:0]         meas_i,
  input  logic [ByteW-1:0]         prior_i,
  input  logic [PROB_FRAC_BITS:0]  p_occ_given_occ_i,
  input  logic [PROB_FRAC_BITS:0]  p_occ_to_free_i,
  input  logic [PROB_FRAC_BITS:0]  p_free_to_free_i,
  input  logic [PROB_FRAC_BITS:0]  p_free_to_occ_i,
  input  logic [RatioW-1:0]        unknown_ratio_i,
  input  codes_t                   codes_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [NW-1:0]            dividend_o,
  output logic [DW-1:0]            divisor_o,
  output logic                     force_one_o
);

  localparam int unsigned PW  = PROB_FRAC_BITS + 1;
  localparam int unsigned AW  = (PW > RatioW) ? PW : RatioW;
  localparam int unsigned MW  = AW + ByteW;
  localparam logic [PW-1:0] ProbOne = PW'(1) << PROB_FRAC_BITS;

  function automatic logic [PW-1:0] sat_prob(input logic [PW-1:0] p);
    return (p > ProbOne) ? ProbOne : p;
  endfunction

  // stage A: decode and multiply
  kind_e          kind_d, kind_q;
  logic [AW-1:0]  op_a, op_b;
  logic [MW-1:0]  prod_a_d, prod_a_q, prod_b_d, prod_b_q;
  logic           va_q, ready_a;

  // stage B: dividend and divisor
  logic [NW-1:0]  num_w, den_w, n_d, n_q, num_u, den_u;
  logic [DW-1:0]  d_d, d_q;
  logic           one_d, one_q;
  logic           vb_q, ready_b;

  // codes are tested in order: occupied, free, unknown
  always_comb begin
    if (meas_i == codes_i.occ) begin
      kind_d = KIND_BAYES;
      op_a   = AW'(sat_prob(p_occ_given_occ_i));
      op_b   = AW'(sat_prob(p_occ_to_free_i));
    end else if (meas_i == codes_i.free) begin
      kind_d = KIND_BAYES;
      op_a   = AW'(ProbOne - sat_prob(p_free_to_free_i));
      op_b   = AW'(ProbOne - sat_prob(p_free_to_occ_i));
    end else if (meas_i == codes_i.unk) begin
      kind_d = KIND_UNKNOWN;
      op_a   = AW'(unknown_ratio_i);
      op_b   = '0;
    end else begin
      kind_d = KIND_OTHER;
      op_a   = '0;
      op_b   = '0;
    end
  end

  assign prod_a_d = MW'(op_a) * MW'(prior_i);
  assign prod_b_d = MW'(op_b) * MW'(BYTE_MAX - prior_i);

  assign ready_b    = !vb_q || out_ready_i;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= in_valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      kind_q   <= kind_d;
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (ready_b && va_q) begin
      n_q   <= n_d;
      d_q   <= d_d;
      one_q <= one_d;
    end
  end

  // bayes: N = 510*num + den, D = 2*den
  // unknown: N = 2*(o*v + 32640) + (256 + v), D = 2*(256 + v)
  assign num_w = NW'(prod_a_q);
  assign den_w = num_w + NW'(prod_b_q);
  assign num_u = NW'(prod_a_q) + NW'(HALF_OFS);
  assign den_u = NW'(unknown_ratio_i) + NW'(RATIO_ONE);

  always_comb begin
    unique case (kind_q)
      KIND_BAYES: begin
        n_d   = (num_w << 9) - (num_w << 1) + den_w;
        d_d   = DW'(den_w << 1);
        one_d = (den_w == '0);
      end
      KIND_UNKNOWN: begin
        n_d   = (num_u << 1) + den_u;
        d_d   = DW'(den_u << 1);
        one_d = 1'b0;
      end
      default: begin
        n_d   = '0;
        d_d   = '0;
        one_d = 1'b1;
      end
    endcase
  end

  assign out_valid_o = vb_q;
  assign dividend_o  = n_q;
  assign divisor_o   = d_q;
  assign force_one_o = one_q;

endmodule

/* hdl/occ_bayes_div.sv */
// ----------------------------------------------------------------------------
// occ_bayes_div
// One stage of the restoring divider: two quotient bits per stage.
// ----------------------------------------------------------------------------
module occ_bayes_div import occ_bayes_pkg::*; #(
  parameter int unsigned DW    = 25,
  parameter int unsigned NW    = 33,
  parameter int unsigned HI    = 7,
  parameter bit          FINAL = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NW-1:0]     rem_i,
  input  logic [DW-1:0]     div_i,
  input  logic [ByteW-1:0]  quo_i,
  input  logic              force_one_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NW-1:0]     rem_o,
  output logic [DW-1:0]     div_o,
  output logic [ByteW-1:0]  quo_o,
  output logic              force_one_o
);

  localparam int unsigned LO = HI - 1;

  logic [NW-1:0]    sh_hi, sh_lo, rem_m, rem_d, rem_q;
  logic [ByteW-1:0] quo_m, quo_r, quo_d, quo_q;
  logic [DW-1:0]    div_q;
  logic             one_q, v_q, ready;

  assign sh_hi = NW'(div_i) << HI;
  assign sh_lo = NW'(div_i) << LO;

  always_comb begin
    rem_m = rem_i;
    quo_m = quo_i;
    if (rem_i >= sh_hi) begin
      rem_m = rem_i - sh_hi;
      quo_m = quo_i | (ByteW'(1) << HI);
    end
    rem_d = rem_m;
    quo_r = quo_m;
    if (rem_m >= sh_lo) begin
      rem_d = rem_m - sh_lo;
      quo_r = quo_m | (ByteW'(1) << LO);
    end
  end

  // last stage folds in the clamp to 1..254 and the forced result
  always_comb begin
    quo_d = quo_r;
    if (FINAL) begin
      priority if (force_one_i)          quo_d = POST_MIN;
      else if (quo_r < POST_MIN)         quo_d = POST_MIN;
      else if (quo_r > POST_MAX)         quo_d = POST_MAX;
      else                               quo_d = quo_r;
    end
  end

  assign ready      = !v_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
      one_q <= force_one_i;
    end
  end

  assign out_valid_o = v_q;
  assign rem_o       = rem_q;
  assign div_o       = div_q;
  assign quo_o       = quo_q;
  assign force_one_o = one_q;

endmodule

/* hdl/occupancy_bayes_cell_update_top.sv */
// ----------------------------------------------------------------------------
// occupancy_bayes_cell_update_top
// Binary Bayes occupancy update of one grid cell per transaction.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, then 4 divider stages of two quotient bits each.
// Throughput: one cell per cycle; the pipeline stalls only on output tready.
// Reset clears every valid bit and loads the register reset values.
// ----------------------------------------------------------------------------
module occupancy_bayes_cell_update_top import occ_bayes_pkg::*; #(
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: [7:0] measured_cost, [15:8] prior_occupancy
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  // tdata: [7:0] posterior_occupancy
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IdxW-1:0]       cfg_index_i,
  input  logic [((PROB_FRAC_BITS + 1 > RatioW) ? PROB_FRAC_BITS + 1 : RatioW) - 1:0]
                                cfg_data_i
);

  localparam int unsigned CfgW   = (PROB_FRAC_BITS + 1 > RatioW) ?
                                   PROB_FRAC_BITS + 1 : RatioW;
  localparam int unsigned DW     = (PROB_FRAC_BITS + 9 > 18) ? PROB_FRAC_BITS + 9 : 18;
  localparam int unsigned NW     = DW + ByteW;
  localparam int unsigned NStage = ByteW / 2;

  logic [PROB_FRAC_BITS:0] poo, pof, pff, pfo;
  logic [RatioW-1:0]       ratio;
  codes_t                  codes;

  logic [NStage:0]         vld, rdy, one;
  logic [NW-1:0]           rem   [NStage+1];
  logic [DW-1:0]           dvs   [NStage+1];
  logic [ByteW-1:0]        quo   [NStage+1];

  occ_bayes_cfg #(
    .PROB_FRAC_BITS (PROB_FRAC_BITS),
    .CfgW           (CfgW)
  ) u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .p_occ_given_occ_o (poo),
    .p_occ_to_free_o   (pof),
    .p_free_to_free_o  (pff),
    .p_free_to_occ_o   (pfo),
    .unknown_ratio_o   (ratio),
    .codes_o           (codes)
  );

  occ_bayes_front #(
    .PROB_FRAC_BITS (PROB_FRAC_BITS),
    .DW             (DW),
    .NW             (NW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .meas_i            (s_axis_tdata[7:0]),
    .prior_i           (s_axis_tdata[15:8]),
    .p_occ_given_occ_i (poo),
    .p_occ_to_free_i   (pof),
    .p_free_to_free_i  (pff),
    .p_free_to_occ_i   (pfo),
    .unknown_ratio_i   (ratio),
    .codes_i           (codes),
    .out_valid_o       (vld[0]),
    .out_ready_i       (rdy[0]),
    .dividend_o        (rem[0]),
    .divisor_o         (dvs[0]),
    .force_one_o       (one[0])
  );

  assign quo[0] = '0;

  for (genvar g = 0; g < NStage; g++) begin : g_div
    occ_bayes_div #(
      .DW    (DW),
      .NW    (NW),
      .HI    (ByteW - 1 - 2 * g),
      .FINAL (g == NStage - 1)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .rem_i       (rem[g]),
      .div_i       (dvs[g]),
      .quo_i       (quo[g]),
      .force_one_i (one[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .rem_o       (rem[g+1]),
      .div_o       (dvs[g+1]),
      .quo_o       (quo[g+1]),
      .force_one_o (one[g+1])
    );
  end

  assign rdy[NStage]   = m_axis_tready;
  assign m_axis_tvalid = vld[NStage];
  assign m_axis_tdata  = quo[NStage];

endmodule
